### rtl/core/tcrct_pkg.sv
// ----------------------------------------------------------------------------
// tcrct_pkg
// Shared codes and types for the Type-C role and cable tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrct_pkg;

    // opcodes
    localparam logic [1:0] OP_POWER = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CABLE = 2'd2;

    // roles (power: sink/source, data: ufp/dfp)
    localparam logic [1:0] ROLE_NONE = 2'd0;
    localparam logic [1:0] ROLE_SNK  = 2'd1;
    localparam logic [1:0] ROLE_SRC  = 2'd2;
    localparam logic [1:0] ROLE_SWAP = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NOTICE = 2'd0;
    localparam logic [1:0] KIND_POLICY = 2'd1;
    localparam logic [1:0] KIND_PULL   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // cable ids
    localparam logic [1:0] CBL_TYPEC_SRC = 2'd0;
    localparam logic [1:0] CBL_TYPEC_SNK = 2'd1;
    localparam logic [1:0] CBL_USB_DEV   = 2'd2;
    localparam logic [1:0] CBL_USB_HOST  = 2'd3;

    // policy events
    localparam logic [1:0] POL_UFP_CONN = 2'd0;
    localparam logic [1:0] POL_UFP_DISC = 2'd1;
    localparam logic [1:0] POL_DFP_CONN = 2'd2;
    localparam logic [1:0] POL_DFP_DISC = 2'd3;

    // most results one request can cause
    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] cable;
        logic       att;
        logic       pu;
        logic [1:0] pol;
    } t_item;

endpackage

`default_nettype wire

### rtl/core/typec_role_and_cable_tracker_unit.sv
// ----------------------------------------------------------------------------
// typec_role_and_cable_tracker_unit
// Tracks Type-C power/data roles and cable attach states; emits cable
// notices, policy events and CC pull commands for each request.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | i_valid / o_stall    | opcode, requested_role, cable_is_provider,
//          |                      | cable_plugged
//  out     | o_valid / i_stall    | event_kind, cable_id, notice_attached,
//          |                      | pull_up, policy_event, status, last
//
//  A request is decoded in the cycle it is accepted: the role/attach state
//  and a burst buffer of one to three results load at that edge. Results
//  leave one per cycle while i_stall is low. A new request is taken in
//  the same cycle the last result of the previous burst is taken.
//  Synchronous active-low reset clears all roles and attach states and
//  empties the burst buffer. i_stall holds the current result in place.
// ----------------------------------------------------------------------------
`default_nettype none

module typec_role_and_cable_tracker_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // request channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [1:0] i_requested_role,
    input  wire logic       i_cable_is_provider,
    input  wire logic       i_cable_plugged,
    // result channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_event_kind,
    output logic [1:0]      o_cable_id,
    output logic            o_notice_attached,
    output logic            o_pull_up,
    output logic [1:0]      o_policy_event,
    output logic            o_provider_is_attached,
    output logic            o_consumer_is_attached,
    output logic [1:0]      o_power_role_now,
    output logic [1:0]      o_data_role_now,
    output logic            o_last
);

    // role and attach state
    logic [1:0] r_pwr_cur, r_pwr_prev, r_data_cur, r_data_prev;
    logic       r_prov, r_cons;
    logic [1:0] n_pwr_cur, n_pwr_prev, n_data_cur, n_data_prev;
    logic       n_prov, n_cons;

    // burst buffer
    tcrct_pkg::t_item r_item [tcrct_pkg::MAX_RESULTS];
    tcrct_pkg::t_item n_item [tcrct_pkg::MAX_RESULTS];
    logic [1:0]       r_last_idx, n_last_idx;
    logic [1:0]       r_idx;
    logic             r_valid;

    logic in_acc, out_acc, burst_end;

    assign burst_end = (r_idx == r_last_idx);
    assign out_acc   = r_valid && !i_stall;
    // take a new request when the buffer is empty or drains this cycle
    assign o_stall   = r_valid && !(out_acc && burst_end);
    assign in_acc    = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Request decode: next state and the results in emission order
    // ------------------------------------------------------------------
    always_comb begin
        logic [1:0] cnt;
        logic       take;
        logic       do_pull;
        logic       pu;
        logic [1:0] eff;
        logic [1:0] cbl;
        logic       att;

        cnt     = 2'd0;
        take    = 1'b0;
        do_pull = 1'b0;
        pu      = 1'b0;
        eff     = r_data_cur;
        cbl     = tcrct_pkg::CBL_TYPEC_SRC;
        att     = 1'b0;

        n_pwr_cur   = r_pwr_cur;
        n_pwr_prev  = r_pwr_prev;
        n_data_cur  = r_data_cur;
        n_data_prev = r_data_prev;
        n_prov      = r_prov;
        n_cons      = r_cons;
        for (int k = 0; k < tcrct_pkg::MAX_RESULTS; k++) begin
            n_item[k] = '0;
        end

        unique case (i_opcode)
            tcrct_pkg::OP_POWER: begin
                if (i_requested_role != r_pwr_cur) begin
                    take = 1'b1;
                    case (i_requested_role)
                        tcrct_pkg::ROLE_SWAP: begin
                            if (r_pwr_cur == tcrct_pkg::ROLE_SRC) begin
                                n_prov = 1'b0;
                                n_item[cnt] = '{tcrct_pkg::KIND_NOTICE,
                                                tcrct_pkg::CBL_TYPEC_SRC, 1'b0, 1'b0, 2'd0};
                                cnt     = cnt + 2'd1;
                                do_pull = 1'b1;
                                pu      = 1'b0;
                            end else if (r_pwr_cur == tcrct_pkg::ROLE_SNK) begin
                                n_cons = 1'b0;
                                n_item[cnt] = '{tcrct_pkg::KIND_NOTICE,
                                                tcrct_pkg::CBL_TYPEC_SNK, 1'b0, 1'b0, 2'd0};
                                cnt     = cnt + 2'd1;
                                do_pull = 1'b1;
                                pu      = 1'b1;
                            end else begin
                                // swap from none: ignore
                                take = 1'b0;
                            end
                        end
                        tcrct_pkg::ROLE_SNK: begin
                            if (r_pwr_cur == tcrct_pkg::ROLE_SWAP &&
                                r_pwr_prev == tcrct_pkg::ROLE_SNK) begin
                                do_pull = 1'b1;
                                pu      = 1'b0;
                            end else if (r_pwr_cur == tcrct_pkg::ROLE_SRC &&
                                         r_pwr_prev == tcrct_pkg::ROLE_SWAP) begin
                                do_pull = 1'b1;
                                pu      = 1'b0;
                                n_prov  = 1'b0;
                                n_item[cnt] = '{tcrct_pkg::KIND_NOTICE,
                                                tcrct_pkg::CBL_TYPEC_SRC, 1'b0, 1'b0, 2'd0};
                                cnt = cnt + 2'd1;
                            end
                            n_cons = 1'b1;
                            n_item[cnt] = '{tcrct_pkg::KIND_NOTICE,
                                            tcrct_pkg::CBL_TYPEC_SNK, 1'b1, 1'b0, 2'd0};
                            cnt = cnt + 2'd1;
                        end
                        tcrct_pkg::ROLE_SRC: begin
                            if (r_pwr_cur == tcrct_pkg::ROLE_SWAP &&
                                r_pwr_prev == tcrct_pkg::ROLE_SRC) begin
                                do_pull = 1'b1;
                                pu      = 1'b1;
                            end
                            n_prov = 1'b1;
                            n_item[cnt] = '{tcrct_pkg::KIND_NOTICE,
                                            tcrct_pkg::CBL_TYPEC_SRC, 1'b1, 1'b0, 2'd0};
                            cnt = cnt + 2'd1;
                        end
                        default: begin
                            // none: detach notice only; from swap it has no cable
                            if (r_pwr_cur == tcrct_pkg::ROLE_SRC) begin
                                n_item[cnt] = '{tcrct_pkg::KIND_NOTICE,
                                                tcrct_pkg::CBL_TYPEC_SRC, 1'b0, 1'b0, 2'd0};
                                cnt = cnt + 2'd1;
                            end else if (r_pwr_cur == tcrct_pkg::ROLE_SNK) begin
                                n_item[cnt] = '{tcrct_pkg::KIND_NOTICE,
                                                tcrct_pkg::CBL_TYPEC_SNK, 1'b0, 1'b0, 2'd0};
                                cnt = cnt + 2'd1;
                            end
                        end
                    endcase
                    if (take) begin
                        n_pwr_prev = r_pwr_cur;
                        n_pwr_cur  = i_requested_role;
                        if (do_pull) begin
                            n_item[cnt] = '{tcrct_pkg::KIND_PULL, 2'd0, 1'b0, pu, 2'd0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
            end
            tcrct_pkg::OP_DATA: begin
                if (i_requested_role != r_data_cur) begin
                    take = 1'b1;
                    if (i_requested_role == tcrct_pkg::ROLE_SWAP ||
                        i_requested_role == tcrct_pkg::ROLE_NONE) begin
                        // leaving a swap detaches the cable of the role before it
                        if (i_requested_role == tcrct_pkg::ROLE_NONE &&
                            r_data_cur == tcrct_pkg::ROLE_SWAP) begin
                            eff = r_data_prev;
                        end
                        att = 1'b0;
                        if (eff == tcrct_pkg::ROLE_SRC) begin
                            cbl = tcrct_pkg::CBL_USB_HOST;
                        end else if (eff == tcrct_pkg::ROLE_SNK) begin
                            cbl = tcrct_pkg::CBL_USB_DEV;
                        end else begin
                            take = 1'b0;
                        end
                    end else if (i_requested_role == tcrct_pkg::ROLE_SNK) begin
                        cbl = tcrct_pkg::CBL_USB_DEV;
                        att = 1'b1;
                    end else begin
                        cbl = tcrct_pkg::CBL_USB_HOST;
                        att = 1'b1;
                    end
                    if (take) begin
                        n_data_prev = r_data_cur;
                        n_data_cur  = i_requested_role;
                        n_item[cnt] = '{tcrct_pkg::KIND_NOTICE, cbl, att, 1'b0, 2'd0};
                        cnt = cnt + 2'd1;
                    end
                end
            end
            tcrct_pkg::OP_CABLE: begin
                if (!i_cable_is_provider) begin
                    if (i_cable_plugged != r_cons) begin
                        n_cons = i_cable_plugged;
                        n_item[cnt] = '{tcrct_pkg::KIND_POLICY, 2'd0, 1'b0, 1'b0,
                                        i_cable_plugged ? tcrct_pkg::POL_UFP_CONN
                                                        : tcrct_pkg::POL_UFP_DISC};
                        cnt = cnt + 2'd1;
                    end
                end else begin
                    if (i_cable_plugged != r_prov) begin
                        n_prov = i_cable_plugged;
                        n_item[cnt] = '{tcrct_pkg::KIND_POLICY, 2'd0, 1'b0, 1'b0,
                                        i_cable_plugged ? tcrct_pkg::POL_DFP_CONN
                                                        : tcrct_pkg::POL_DFP_DISC};
                        cnt = cnt + 2'd1;
                    end
                end
            end
            default: begin
                // unused opcode: no state change, only the KIND_NONE result
            end
        endcase

        if (cnt == 2'd0) begin
            n_item[0] = '{tcrct_pkg::KIND_NONE, 2'd0, 1'b0, 1'b0, 2'd0};
            cnt = 2'd1;
        end
        n_last_idx = cnt - 2'd1;
    end

    // ------------------------------------------------------------------
    // State and burst registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwr_cur   <= tcrct_pkg::ROLE_NONE;
            r_pwr_prev  <= tcrct_pkg::ROLE_NONE;
            r_data_cur  <= tcrct_pkg::ROLE_NONE;
            r_data_prev <= tcrct_pkg::ROLE_NONE;
            r_prov      <= 1'b0;
            r_cons      <= 1'b0;
            r_valid     <= 1'b0;
            r_idx       <= 2'd0;
            r_last_idx  <= 2'd0;
        end else if (in_acc) begin
            // load the new burst and commit the state
            r_pwr_cur   <= n_pwr_cur;
            r_pwr_prev  <= n_pwr_prev;
            r_data_cur  <= n_data_cur;
            r_data_prev <= n_data_prev;
            r_prov      <= n_prov;
            r_cons      <= n_cons;
            r_valid     <= 1'b1;
            r_idx       <= 2'd0;
            r_last_idx  <= n_last_idx;
        end else if (out_acc) begin
            // advance through the burst, drop valid after the last result
            if (burst_end) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= n_item;
        end
    end

    // ------------------------------------------------------------------
    // Outputs: state is stable while a burst drains
    // ------------------------------------------------------------------
    assign o_valid                = r_valid;
    assign o_event_kind           = r_item[r_idx].kind;
    assign o_cable_id             = r_item[r_idx].cable;
    assign o_notice_attached      = r_item[r_idx].att;
    assign o_pull_up              = r_item[r_idx].pu;
    assign o_policy_event         = r_item[r_idx].pol;
    assign o_provider_is_attached = r_prov;
    assign o_consumer_is_attached = r_cons;
    assign o_power_role_now       = r_pwr_cur;
    assign o_data_role_now        = r_data_cur;
    assign o_last                 = burst_end;

endmodule

`default_nettype wire
